// ===== hdl/ucd_pkg.sv =====
// Shared types and constants for the undirected cycle detector.
package ucd_pkg;

  localparam int MaxVertices = 256;
  localparam int VertexW     = 8;
  localparam int CountW      = 9;
  localparam logic [CountW-1:0] CountReset = 9'd256;

  typedef enum logic {
    ACT_ADD    = 1'b0,
    ACT_REPORT = 1'b1
  } action_e;

  typedef struct packed {
    action_e              action;
    logic [VertexW-1:0]   vertex_a;
    logic [VertexW-1:0]   vertex_b;
  } in_item_t;

  typedef struct packed {
    logic has_cycle;
    logic bad_vertex;
  } result_t;

  typedef enum logic [1:0] {
    ST_CLEAR  = 2'd0,
    ST_IDLE   = 2'd1,
    ST_FIND_A = 2'd2,
    ST_FIND_B = 2'd3
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic accept_edge;
    logic accept_report;
    logic mark_range;
    logic walk;
    logic to_b;
    logic finish;
    logic clear_wr;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic in_range;
    logic at_root;
    logic clr_last;
  } status_t;

endpackage

// ===== hdl/ucd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module ucd_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(Depth)-1:0] wr_addr_i,
  input  logic [Width-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(Depth)-1:0] rd_addr_i,
  output logic [Width-1:0]         rd_data_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== hdl/ucd_ctrl.sv =====
// Sequencer for the cycle detector: clear sweep, edge intake and root walks.
module ucd_ctrl
  import ucd_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start,
  input  action_e action_i,
  input  status_t status_i,
  output cmd_t    cmd_o,
  output logic    busy
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy    = 1'b1;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clear_wr = 1'b1;
        if (status_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          if (action_i == ACT_REPORT) begin
            cmd_o.accept_report = 1'b1;
            state_d             = ST_CLEAR;
          end else if (!status_i.in_range) begin
            cmd_o.mark_range = 1'b1;
          end else begin
            cmd_o.accept_edge = 1'b1;
            state_d           = ST_FIND_A;
          end
        end
      end
      ST_FIND_A: begin
        if (status_i.at_root) begin
          cmd_o.to_b = 1'b1;
          state_d    = ST_FIND_B;
        end else begin
          cmd_o.walk = 1'b1;
        end
      end
      ST_FIND_B: begin
        if (status_i.at_root) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end else begin
          cmd_o.walk = 1'b1;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  // A report always starts a full clear sweep
  a_report_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.accept_report |=> (state_q == ST_CLEAR))
    else $error("report not followed by clear sweep");

endmodule

// ===== hdl/ucd_datapath.sv =====
// Datapath: leader memory, walk pointers, flags, range check and result register.
module ucd_datapath
  import ucd_pkg::*;
#(
  parameter int MAX_VERTICES = MaxVertices
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  in_item_t          in_item_i,
  input  logic              cfg_we_i,
  input  logic [CountW-1:0] cfg_wdata_i,
  input  cmd_t              cmd_i,
  output status_t           status_o,
  output logic              result_valid_o,
  output result_t           result_o
);

  localparam int VW = $clog2(MAX_VERTICES);
  localparam int XW = (VW > VertexW) ? VW : VertexW;
  localparam int LW = $clog2(MAX_VERTICES + 1);
  localparam int CW = (LW > CountW) ? LW : CountW;
  localparam logic [CW-1:0] MaxC = CW'(MAX_VERTICES);
  localparam logic [VW-1:0] LastIdx = VW'(MAX_VERTICES - 1);

  logic [CountW-1:0] count_q;
  logic [VW-1:0]     cur_q, b_q, ra_q, clr_q;
  logic              cycle_q, range_q;
  logic              valid_q;
  result_t           result_q;

  logic [VW-1:0]     rd_data;
  logic              rd_en, wr_en;
  logic [VW-1:0]     rd_addr, wr_addr, wr_data;
  logic [XW-1:0]     a_x, b_x;
  logic [CW-1:0]     count_x, limit;
  logic              same_root;

  assign a_x     = XW'(in_item_i.vertex_a);
  assign b_x     = XW'(in_item_i.vertex_b);
  assign count_x = CW'(count_q);
  assign limit   = (count_x > MaxC) ? MaxC : count_x;

  assign status_o.in_range = (CW'(in_item_i.vertex_a) < limit) &&
                             (CW'(in_item_i.vertex_b) < limit);
  assign status_o.at_root  = (rd_data == cur_q);
  assign status_o.clr_last = (clr_q == LastIdx);
  assign same_root         = (cur_q == ra_q);

  // Read for the next hop is steered straight from the previous read data
  assign rd_en   = cmd_i.accept_edge | cmd_i.walk | cmd_i.to_b;
  assign rd_addr = cmd_i.accept_edge ? a_x[VW-1:0] :
                   cmd_i.to_b        ? b_q          : rd_data;

  assign wr_en   = cmd_i.clear_wr | (cmd_i.finish & ~same_root);
  assign wr_addr = cmd_i.clear_wr ? clr_q : ra_q;
  assign wr_data = cmd_i.clear_wr ? clr_q : cur_q;

  ucd_ram #(
    .Width (VW),
    .Depth (MAX_VERTICES)
  ) u_leader_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= CountReset;
      clr_q   <= '0;
      cycle_q <= 1'b0;
      range_q <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      valid_q <= cmd_i.accept_report;
      if (cfg_we_i) begin
        count_q <= cfg_wdata_i;
      end
      if (cmd_i.clear_wr) begin
        clr_q <= clr_q + 1'b1;
      end
      if (cmd_i.accept_report) begin
        clr_q   <= '0;
        cycle_q <= 1'b0;
        range_q <= 1'b0;
      end
      if (cmd_i.mark_range) begin
        range_q <= 1'b1;
      end
      if (cmd_i.finish && same_root) begin
        cycle_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept_edge) begin
      cur_q <= a_x[VW-1:0];
      b_q   <= b_x[VW-1:0];
    end else if (cmd_i.to_b) begin
      ra_q  <= cur_q;
      cur_q <= b_q;
    end else if (cmd_i.walk) begin
      cur_q <= rd_data;
    end
    if (cmd_i.accept_report) begin
      result_q.has_cycle  <= cycle_q;
      result_q.bad_vertex <= range_q;
    end
  end

  assign result_valid_o = valid_q;
  assign result_o       = result_q;

  a_valid_from_report: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> $past(cmd_i.accept_report))
    else $error("result beat without a report");

  a_flags_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.accept_report |=> (!cycle_q && !range_q))
    else $error("flags survive a report");

  a_finish_at_root: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish |-> status_o.at_root)
    else $error("link issued before reaching a root");

endmodule

// ===== hdl/undirected_cycle_detect_core.sv =====
// Top level of the undirected graph cycle detector.
//
// Usage: load the edges of one graph as items with action add, then issue an
// item with action report. An item is taken at a clock edge where start is
// high and busy is low. A report produces one result beat on result_o in the
// following cycle, marked by result_valid_o for exactly one cycle; the receiver
// cannot stall it. Add items produce no beat.
// Walk: an in-range edge follows the hops from each endpoint up to its
// component root in the leader RAM (one registered RAM read per hop). An
// out-of-range edge only sets the flag. A report is followed by a clear sweep
// that rewrites every leader to its own index.
// Reset: the block comes out of reset running the same clear sweep with busy
// high; vertex_count resets to 256 and may be written through
// cfg_we_i/cfg_wdata_i at any time, including during the sweep.
module undirected_cycle_detect_core
  import ucd_pkg::*;
#(
  parameter int MAX_VERTICES = MaxVertices
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  in_item_t          in_item_i,
  input  logic              cfg_we_i,
  input  logic [CountW-1:0] cfg_wdata_i,
  output logic              result_valid_o,
  output result_t           result_o
);

  cmd_t    cmd;
  status_t status;

  ucd_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .action_i (in_item_i.action),
    .status_i (status),
    .cmd_o    (cmd),
    .busy     (busy)
  );

  ucd_datapath #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_item_i      (in_item_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .cmd_i          (cmd),
    .status_o       (status),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

endmodule

// ===== dv/tb_undirected_cycle_detect_core.sv =====
// Self-checking testbench for undirected_cycle_detect_core: directed graphs, then random graphs.
module tb_undirected_cycle_detect_core;
  import ucd_pkg::*;

  localparam int RandomItems   = 1650;
  localparam int PhaseCount    = 10;
  localparam int SettleCycles  = 16;
  localparam int DrainCycles   = 2 * MaxVertices;
  // worst quiet stretch is one edge walking two full chains, or one clear sweep
  localparam int WatchdogLimit = 8 * (3 + 2 * MaxVertices);
  localparam int MaxReported   = 10;

  logic              clk_i        = 1'b0;
  logic              rst_ni       = 1'b0;
  logic              start        = 1'b0;
  logic              busy;
  in_item_t          in_item      = '0;
  logic              cfg_we       = 1'b0;
  logic [CountW-1:0] cfg_wdata    = '0;
  logic              result_valid;
  result_t           result;

  undirected_cycle_detect_core #(
    .MAX_VERTICES(MaxVertices)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .in_item_i     (in_item),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata),
    .result_valid_o(result_valid),
    .result_o      (result)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Component tracker: leader table, flags and vertex count as the block should hold them
  logic [VertexW-1:0] leader_q [MaxVertices];
  logic               cycle_q;
  logic               range_err_q;
  logic [CountW-1:0]  vertex_count_q;
  result_t            expected_reports [$];

  int  errors       = 0;
  int  items_sent   = 0;
  int  reports_sent = 0;
  int  results_seen = 0;
  int  count_writes = 0;
  bit  no_idle      = 1'b0;

  function automatic void clear_components();
    for (int i = 0; i < MaxVertices; i++) leader_q[i] = i[VertexW-1:0];
    cycle_q     = 1'b0;
    range_err_q = 1'b0;
  endfunction

  function automatic logic [VertexW-1:0] root_of(input logic [VertexW-1:0] v);
    logic [VertexW-1:0] up;
    for (int steps = 0; steps < MaxVertices; steps++) begin
      up = leader_q[v];
      if (up == v) break;
      v = up;
    end
    return v;
  endfunction

  function automatic void track_components(input in_item_t item);
    int                 limit;
    logic [VertexW-1:0] ra;
    logic [VertexW-1:0] rb;
    result_t            r;
    limit = (int'(vertex_count_q) > MaxVertices) ? MaxVertices : int'(vertex_count_q);
    if (item.action == ACT_REPORT) begin
      r.has_cycle  = cycle_q;
      r.bad_vertex = range_err_q;
      expected_reports = {expected_reports, r};
      reports_sent++;
      clear_components();
    end else if (int'(item.vertex_a) >= limit || int'(item.vertex_b) >= limit) begin
      range_err_q = 1'b1;
    end else begin
      ra = root_of(item.vertex_a);
      rb = root_of(item.vertex_b);
      if (ra == rb) cycle_q = 1'b1;
      else leader_q[ra] = rb;
    end
  endfunction

  task automatic note_failure(input string msg);
    errors++;
    if (errors <= MaxReported) $display("ERROR @%0t: %s", $time, msg);
  endtask

  function automatic in_item_t edge_item(input int a, input int b);
    in_item_t it;
    it.action   = ACT_ADD;
    it.vertex_a = a[VertexW-1:0];
    it.vertex_b = b[VertexW-1:0];
    return it;
  endfunction

  // endpoints of a report beat are don't-care, so keep them random
  function automatic in_item_t report_item();
    in_item_t it;
    it.action   = ACT_REPORT;
    it.vertex_a = VertexW'($urandom);
    it.vertex_b = VertexW'($urandom);
    return it;
  endfunction

  // start is left high on return so back-to-back beats need no second assignment
  task automatic send_item(input in_item_t item);
    if (!no_idle && $urandom_range(99) < 9) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    start   <= 1'b1;
    in_item <= item;
    do @(posedge clk_i); while (busy);
    track_components(item);
    items_sent++;
  endtask

  task automatic settle();
    start <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  task automatic write_count(input int v);
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= v[CountW-1:0];
    @(posedge clk_i);
    vertex_count_q = v[CountW-1:0];
    count_writes++;
    cfg_we <= 1'b0;
  endtask

  // Result checker: the strobe lasts one cycle and cannot be held off
  result_t expected_r;
  always @(posedge clk_i) begin
    if (rst_ni && result_valid) begin
      results_seen++;
      if (expected_reports.size() == 0) begin
        note_failure($sformatf("unexpected result beat cyc=%0b bad=%0b",
                               result.has_cycle, result.bad_vertex));
      end else begin
        expected_r = expected_reports.pop_front();
        if (result.has_cycle !== expected_r.has_cycle ||
            result.bad_vertex !== expected_r.bad_vertex) begin
          note_failure($sformatf("report %0d: expected cyc=%0b bad=%0b, got cyc=%0b bad=%0b",
                                 results_seen, expected_r.has_cycle, expected_r.bad_vertex,
                                 result.has_cycle, result.bad_vertex));
        end
      end
    end
  end

  // Watchdog on cycles with no beat in either direction
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WatchdogLimit) begin
      @(posedge clk_i);
      if ((rst_ni && start && !busy) || (rst_ni && result_valid)) quiet = 0;
      else quiet++;
    end
    $display("timeout: no beat for %0d cycles", WatchdogLimit);
    $display("tb_undirected_cycle_detect_core NOT OK");
    $finish;
  end

  task automatic test_small_graphs();
    send_item(report_item());                 // empty graph
    send_item(edge_item(0, 255));
    send_item(edge_item(255, 0));             // same edge both ways
    send_item(report_item());
    send_item(edge_item(7, 7));               // self-loop
    send_item(report_item());
    send_item(edge_item(0, 1));
    send_item(edge_item(1, 2));
    send_item(edge_item(2, 3));               // path, no cycle
    send_item(report_item());
  endtask

  task automatic test_count_extremes();
    write_count(0);                           // everything out of range
    send_item(edge_item(0, 0));
    send_item(report_item());
    write_count(1);
    send_item(edge_item(0, 0));
    send_item(edge_item(0, 1));
    send_item(report_item());
    write_count(2);
    send_item(edge_item(0, 1));
    send_item(edge_item(1, 2));
    send_item(report_item());
    write_count(511);                         // clamps to full capacity
    send_item(edge_item(255, 255));
    send_item(edge_item(254, 253));
    send_item(report_item());
  endtask

  task automatic test_count_change_mid_graph();
    write_count(256);
    send_item(edge_item(200, 201));
    write_count(100);                         // edge above stays, reverse now flagged
    send_item(edge_item(201, 200));
    send_item(edge_item(5, 6));
    send_item(report_item());
  endtask

  task automatic test_random_graphs();
    int cnt;
    int limit;
    int span;
    int base;
    int n_edges;
    int r;
    int a;
    int b;
    int phase_start;
    for (int phase = 0; phase < PhaseCount; phase++) begin
      case (phase)
        0:       cnt = 256;
        1:       cnt = 511;
        2:       cnt = 1;
        3:       cnt = 2;
        4:       cnt = 16;
        5:       cnt = 100;
        6:       cnt = 0;
        7:       cnt = 257;
        default: cnt = $urandom_range(0, 511);
      endcase
      write_count(cnt);
      no_idle     = (phase == 4);
      limit       = (cnt > MaxVertices) ? MaxVertices : cnt;
      phase_start = items_sent;
      while (items_sent - phase_start < RandomItems / PhaseCount) begin
        r = $urandom_range(99);
        if (r < 85)      n_edges = $urandom_range(0, 12);
        else if (r < 98) n_edges = $urandom_range(13, 40);
        else             n_edges = $urandom_range(41, 200);
        span = 1;
        base = 0;
        if (limit > 0) begin
          // narrow spans make cycles likely, wide ones make forests
          span = ($urandom_range(99) < 70) ? $urandom_range(1, (limit < 32) ? limit : 32)
                                           : limit;
          base = $urandom_range(0, limit - span);
        end
        for (int e = 0; e < n_edges; e++) begin
          if (limit == 0) begin
            a = $urandom_range(0, 255);
            b = $urandom_range(0, 255);
          end else if (limit < MaxVertices && $urandom_range(99) < 6) begin
            a = $urandom_range(0, 255);
            b = $urandom_range(limit, 255);
            if ($urandom_range(1)) begin
              r = a;
              a = b;
              b = r;
            end
          end else begin
            a = base + $urandom_range(0, span - 1);
            b = base + $urandom_range(0, span - 1);
          end
          send_item(edge_item(a, b));
        end
        send_item(report_item());
      end
    end
    no_idle = 1'b0;
  endtask

  initial begin
    clear_components();
    vertex_count_q = CountReset;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_small_graphs();
    test_count_extremes();
    test_count_change_mid_graph();
    test_random_graphs();
    settle();
    repeat (DrainCycles) @(posedge clk_i);
    if (expected_reports.size() != 0) begin
      note_failure($sformatf("%0d reports never answered", expected_reports.size()));
    end
    $display("Sent %0d beats over %0d graphs, %0d results checked, %0d mismatches.",
             items_sent, reports_sent, results_seen, errors);
    $display("Vertex count written %0d times: 0, 1, 2, 511, 257, mid-graph change and random.",
             count_writes);
    if (errors == 0) begin
      $display("tb_undirected_cycle_detect_core OK");
    end else begin
      $display("tb_undirected_cycle_detect_core NOT OK");
    end
    $finish;
  end

endmodule
